### sv/adms_pkg.sv
`timescale 1ns / 1ps

package adms_pkg;

  // Field widths
  localparam int ANGLE_W = 54;
  localparam int UNIT_W  = 2;
  localparam int KIND_W  = 2;
  localparam int DMS_W   = 40;
  localparam int STAT_W  = 3;

  localparam int FRAC_BITS_DEF = 24;

  // Pipeline registers between the input register and the result register
  localparam int MID_STAGES = 4;

  // Unit codes
  localparam logic [UNIT_W-1:0] UNIT_DEG = 2'd0;
  localparam logic [UNIT_W-1:0] UNIT_MIN = 2'd1;
  localparam logic [UNIT_W-1:0] UNIT_SEC = 2'd2;
  localparam logic [UNIT_W-1:0] UNIT_DMS = 2'd3;

  // Angle kinds; code three behaves as other
  localparam logic [KIND_W-1:0] KIND_LAT   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LON   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_OTHER = 2'd2;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK      = 3'd0;
  localparam logic [STAT_W-1:0] ST_RANGE   = 3'd1;
  localparam logic [STAT_W-1:0] ST_NONPOS  = 3'd2;
  localparam logic [STAT_W-1:0] ST_BAD_MIN = 3'd3;
  localparam logic [STAT_W-1:0] ST_BAD_SEC = 3'd4;

  // Internal widths
  localparam int MSU_W      = 22;  // milliseconds per unit
  localparam int WHOLE_LO_W = 21;  // whole units kept; anything above is out of range
  localparam int MS_W       = WHOLE_LO_W + MSU_W + 1;
  localparam int MS31_W     = 31;  // in-range milliseconds
  localparam int LIMMS_W    = 31;
  localparam int TMQ_W      = 16;  // total minutes estimate
  localparam int TM_W       = 17;
  localparam int SS_W       = 16;
  localparam int DD_W       = 9;
  localparam int MM_W       = 6;
  localparam int PK_W       = 39;  // packed magnitude in thousandths
  localparam int WC_W       = 29;  // whole part of a packed input
  localparam int QM_W       = 10;
  localparam int WM_W       = 20;
  localparam int QK_W       = 11;
  localparam int WK_W       = 10;

  // Constants
  localparam longint MS_PER_MIN   = 60000;
  localparam longint MS_PER_SEC   = 1000;
  localparam longint SS_CARRY     = 59999;
  localparam longint MIN_PER_DEG  = 60;
  localparam longint PK_PER_DEG   = 1000000000;
  localparam longint PK_PER_MIN   = 1000000;
  localparam longint MEGA         = 1000000;
  localparam longint KILO         = 1000;
  localparam longint BAD_MIN_LIM  = 60060;
  localparam longint BAD_SEC_LIM  = 60;

  // Reciprocals for constant division (floor of 2^SH / d)
  localparam longint RECIP_MIN    = 71582;  // 1/60000
  localparam int     RECIP_MIN_SH = 32;
  localparam longint RECIP_HR     = 1092;   // 1/60
  localparam int     RECIP_HR_SH  = 16;
  localparam longint RECIP_MEGA   = 536;    // 1/1000000
  localparam int     RECIP_MEGA_SH = 29;
  localparam longint RECIP_KILO   = 1048;   // 1/1000
  localparam int     RECIP_KILO_SH = 20;

  typedef struct packed {
    logic [UNIT_W-1:0] unit;
    logic [KIND_W-1:0] kind;
    logic              neg;
  } ctl_t;

  typedef struct packed {
    logic            oor;
    logic [DD_W-1:0] dd;
    logic [MM_W-1:0] mm;
    logic [SS_W-1:0] ss;
  } conv_res_t;

  typedef struct packed {
    logic            bad;
    logic            zero;
    logic            pnz;
    logic [WM_W-1:0] wm;
    logic [QK_W-1:0] qk0;
    logic [PK_W-1:0] val;
  } pchk_res_t;

  function automatic logic [MSU_W-1:0] ms_per_unit(input logic [UNIT_W-1:0] unit);
    logic [MSU_W-1:0] k;
    unique case (unit)
      UNIT_MIN: k = MSU_W'(60000);
      UNIT_SEC: k = MSU_W'(1000);
      default:  k = MSU_W'(3600000);
    endcase
    return k;
  endfunction

  function automatic logic [LIMMS_W-1:0] lim_ms(input logic [KIND_W-1:0] kind);
    logic [LIMMS_W-1:0] l;
    unique case (kind)
      KIND_LAT: l = LIMMS_W'(324000000);
      KIND_LON: l = LIMMS_W'(648000000);
      default:  l = LIMMS_W'(1296000000);
    endcase
    return l;
  endfunction

  function automatic logic [WC_W-1:0] lim_packed(input logic [KIND_W-1:0] kind);
    logic [WC_W-1:0] l;
    unique case (kind)
      KIND_LAT: l = WC_W'(90000000);
      KIND_LON: l = WC_W'(180000000);
      default:  l = WC_W'(360000000);
    endcase
    return l;
  endfunction

endpackage

### sv/adms_if.sv
`timescale 1ns / 1ps

interface adms_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [adms_pkg::ANGLE_W-1:0] angle_value;
  logic        [adms_pkg::UNIT_W-1:0]  unit_code;
  logic        [adms_pkg::KIND_W-1:0]  angle_kind;

  modport source (output valid, angle_value, unit_code, angle_kind, input ready);
  modport sink   (input valid, angle_value, unit_code, angle_kind, output ready);
endinterface

interface adms_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [adms_pkg::DMS_W-1:0] dms_value;
  logic        [adms_pkg::STAT_W-1:0] status;

  modport source (output valid, dms_value, status, input ready);
  modport sink   (input valid, dms_value, status, output ready);
endinterface

### sv/adms_conv.sv
`timescale 1ns / 1ps

module adms_conv #(
  parameter int FRAC_BITS = adms_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic [adms_pkg::MID_STAGES-1:0]   en,
  input  logic [adms_pkg::ANGLE_W-1:0]      mag,
  input  adms_pkg::ctl_t                    ctl_s1,
  input  adms_pkg::ctl_t                    ctl_s2,
  output adms_pkg::conv_res_t               res
);
  import adms_pkg::*;

  localparam int WW = ANGLE_W - FRAC_BITS;
  localparam int PW = FRAC_BITS + MSU_W;
  localparam int QP_W = MS31_W + 17;
  localparam int HP_W = TM_W + 11;

  logic [WW-1:0]        whole;
  logic [FRAC_BITS-1:0] part;
  logic [MSU_W-1:0]     k;
  logic [MS_W-1:0]      whole_ms;
  logic [PW-1:0]        frac_prod;
  logic [MS_W-1:0]      ms_nxt;

  logic [MS_W-1:0]      ms_r;
  logic                 big_r;

  logic                 oor_nxt;
  logic [QP_W-1:0]      qprod;
  logic                 oor3_r;
  logic [MS31_W-1:0]    ms31_r;
  logic [TMQ_W-1:0]     q0_r;

  logic [MS31_W-1:0]    rem_full;
  logic [TM_W-1:0]      rem;
  logic                 fix_min;
  logic                 oor4_r;
  logic [TMQ_W-1:0]     tm_r;
  logic [SS_W-1:0]      ss_r;

  logic                 carry;
  logic [TM_W-1:0]      tmc;
  logic [HP_W-1:0]      hprod;
  logic [11:0]          dq;
  logic [TM_W-1:0]      mrem;
  logic                 fix_deg;
  conv_res_t            res_nxt;
  conv_res_t            res_r;

  // Stage 2: whole milliseconds, truncated
  always_comb begin
    whole     = mag[ANGLE_W-1:FRAC_BITS];
    part      = mag[FRAC_BITS-1:0];
    k         = ms_per_unit(ctl_s1.unit);
    whole_ms  = MS_W'(whole[WHOLE_LO_W-1:0]) * MS_W'(k);
    frac_prod = PW'(part) * PW'(k);
    ms_nxt    = whole_ms + MS_W'(frac_prod[PW-1:FRAC_BITS]);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      ms_r  <= ms_nxt;
      big_r <= |whole[WW-1:WHOLE_LO_W];
    end
  end

  // Stage 3: range check, total-minutes estimate
  // One past the limit in ms already packs above it, one below carries to it.
  always_comb begin
    oor_nxt = big_r || (ms_r > MS_W'(lim_ms(ctl_s2.kind))) ||
              (ctl_s2.kind[1] && ctl_s2.neg && (ms_r != '0));
    qprod   = QP_W'(ms_r[MS31_W-1:0]) * QP_W'(RECIP_MIN);
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      oor3_r <= oor_nxt;
      ms31_r <= ms_r[MS31_W-1:0];
      q0_r   <= qprod[QP_W-1:RECIP_MIN_SH];
    end
  end

  // Stage 4: estimate is low by at most one
  always_comb begin
    rem_full = ms31_r - MS31_W'(q0_r) * MS31_W'(MS_PER_MIN);
    rem      = rem_full[TM_W-1:0];
    fix_min  = rem >= TM_W'(MS_PER_MIN);
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      oor4_r <= oor3_r;
      tm_r   <= fix_min ? q0_r + TMQ_W'(1) : q0_r;
      ss_r   <= fix_min ? SS_W'(rem - TM_W'(MS_PER_MIN)) : rem[SS_W-1:0];
    end
  end

  // Stage 5: seconds carry, then minutes split into degrees and minutes
  always_comb begin
    carry   = ss_r >= SS_W'(SS_CARRY);
    tmc     = TM_W'(tm_r) + TM_W'(carry);
    hprod   = HP_W'(tmc) * HP_W'(RECIP_HR);
    dq      = hprod[HP_W-1:RECIP_HR_SH];
    mrem    = tmc - TM_W'(dq) * TM_W'(MIN_PER_DEG);
    fix_deg = mrem >= TM_W'(MIN_PER_DEG);
    res_nxt.oor = oor4_r;
    res_nxt.dd  = DD_W'(dq + 12'(fix_deg));
    res_nxt.mm  = fix_deg ? MM_W'(mrem - TM_W'(MIN_PER_DEG)) : MM_W'(mrem);
    res_nxt.ss  = carry ? '0 : ss_r;
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

### sv/adms_pchk.sv
`timescale 1ns / 1ps

module adms_pchk #(
  parameter int FRAC_BITS = adms_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic [adms_pkg::MID_STAGES-1:0]   en,
  input  logic [adms_pkg::ANGLE_W-1:0]      mag,
  input  adms_pkg::ctl_t                    ctl_s1,
  output adms_pkg::pchk_res_t               res
);
  import adms_pkg::*;

  localparam int WW   = ANGLE_W - FRAC_BITS;
  localparam int CW   = (WW > WC_W) ? WW : WC_W;
  localparam int FP_W = FRAC_BITS + 10;
  localparam int MP_W = WC_W + QM_W;
  localparam int KP_W = WM_W + QK_W;

  logic [WW-1:0]        whole;
  logic [FRAC_BITS-1:0] part;
  logic [CW-1:0]        whole_cw;
  logic [CW-1:0]        lim_cw;
  logic [WC_W-1:0]      wc;
  logic [FP_W-1:0]      frac_prod;
  logic                 bad_nxt;

  logic                 bad2_r, zero2_r, pnz2_r;
  logic [WC_W-1:0]      wc2_r;
  logic [PK_W-1:0]      val2_r;

  logic [MP_W-1:0]      mprod;
  logic                 bad3_r, zero3_r, pnz3_r;
  logic [WC_W-1:0]      wc3_r;
  logic [QM_W-1:0]      qm3_r;
  logic [PK_W-1:0]      val3_r;

  logic [WC_W-1:0]      wm_full;
  logic [WM_W:0]        wm21;
  logic                 fix_mega;
  logic                 bad4_r, zero4_r, pnz4_r;
  logic [WM_W-1:0]      wm4_r;
  logic [PK_W-1:0]      val4_r;

  logic [KP_W-1:0]      kprod;
  pchk_res_t            res_r;

  // Stage 2: range on the exact value, thousandths truncated
  always_comb begin
    whole     = mag[ANGLE_W-1:FRAC_BITS];
    part      = mag[FRAC_BITS-1:0];
    whole_cw  = CW'(whole);
    lim_cw    = CW'(lim_packed(ctl_s1.kind));
    wc        = WC_W'(whole);
    frac_prod = FP_W'(part) * FP_W'(KILO);
    bad_nxt   = (whole_cw > lim_cw) || ((whole_cw == lim_cw) && (part != '0)) ||
                (ctl_s1.kind[1] && ctl_s1.neg && (mag != '0));
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      bad2_r  <= bad_nxt;
      zero2_r <= mag == '0;
      pnz2_r  <= part != '0;
      wc2_r   <= wc;
      val2_r  <= PK_W'(wc) * PK_W'(KILO) + PK_W'(frac_prod[FP_W-1:FRAC_BITS]);
    end
  end

  // Stage 3: quotient estimate by 1e6
  assign mprod = MP_W'(wc2_r) * MP_W'(RECIP_MEGA);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      bad3_r  <= bad2_r;
      zero3_r <= zero2_r;
      pnz3_r  <= pnz2_r;
      wc3_r   <= wc2_r;
      qm3_r   <= mprod[MP_W-1:RECIP_MEGA_SH];
      val3_r  <= val2_r;
    end
  end

  // Stage 4: whole mod 1e6
  always_comb begin
    wm_full  = wc3_r - WC_W'(qm3_r) * WC_W'(MEGA);
    wm21     = wm_full[WM_W:0];
    fix_mega = wm21 >= (WM_W+1)'(MEGA);
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      bad4_r  <= bad3_r;
      zero4_r <= zero3_r;
      pnz4_r  <= pnz3_r;
      wm4_r   <= fix_mega ? WM_W'(wm21 - (WM_W+1)'(MEGA)) : wm21[WM_W-1:0];
      val4_r  <= val3_r;
    end
  end

  // Stage 5: quotient estimate by 1000
  assign kprod = KP_W'(wm4_r) * KP_W'(RECIP_KILO);

  always_ff @(posedge clk) begin
    if (en[3]) begin
      res_r.bad  <= bad4_r;
      res_r.zero <= zero4_r;
      res_r.pnz  <= pnz4_r;
      res_r.wm   <= wm4_r;
      res_r.qk0  <= kprod[KP_W-1:RECIP_KILO_SH];
      res_r.val  <= val4_r;
    end
  end

  assign res = res_r;

endmodule

### sv/angle_to_packed_dms_top.sv
`timescale 1ns / 1ps

// Channel   Dir  Payload                                   Handshake
// in_chan   in   angle_value[53:0] s, unit_code, angle_kind  valid/ready
// out_chan  out  dms_value[39:0] s, status[2:0]             valid/ready
//
// One item per cycle sustained while out_chan.ready stays high; out_chan.valid
// rises once the item has passed the input register, four datapath stages
// and the result register.
// Stage depth is set by the reciprocal divides by 60000, 60, 1e6 and 1000.
// rst_n is synchronous, active low; it clears only the stage valid bits.
// Each stage loads when empty or when the stage after it moves, so bubbles
// collapse and a held result stalls the pipe only once every stage is full.

module angle_to_packed_dms_top #(
  parameter int FRAC_BITS = adms_pkg::FRAC_BITS_DEF
) (
  input logic         clk,
  input logic         rst_n,
  adms_in_if.sink     in_chan,
  adms_out_if.source  out_chan
);
  import adms_pkg::*;

  localparam int NSTAGE = MID_STAGES + 2;
  localparam int WKF_W  = WM_W;

  // Stage valid bits and per-stage load enables
  logic [NSTAGE:1] v_r;
  logic [NSTAGE:1] ld;

  // Input register
  logic [ANGLE_W-1:0] ang1_r;
  logic [UNIT_W-1:0]  unit1_r;
  logic [KIND_W-1:0]  kind1_r;
  logic [ANGLE_W-1:0] mag1;
  ctl_t               ctl1;

  // Side pipeline of control fields, stages 2..5
  ctl_t ctl_r [MID_STAGES];

  conv_res_t conv_res;
  pchk_res_t pchk_res;
  ctl_t      ctl5;

  // Result stage
  logic [PK_W-1:0]   conv_pk;
  logic [WKF_W-1:0]  wk_full;
  logic [WK_W:0]     wk11;
  logic [WK_W-1:0]   wk;
  logic [PK_W-1:0]   mag_out;
  logic [STAT_W-1:0] stat_nxt;
  logic [DMS_W-1:0]  dms_nxt;
  logic [DMS_W-1:0]  dms_r;
  logic [STAT_W-1:0] stat_r;

  // Ready chain: a stage can load if empty or if its item moves on
  always_comb begin
    ld[NSTAGE] = !v_r[NSTAGE] || out_chan.ready;
    for (int i = NSTAGE - 1; i >= 1; i--) begin
      ld[i] = !v_r[i] || ld[i+1];
    end
  end

  assign in_chan.ready = ld[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (ld[1]) begin
        v_r[1] <= in_chan.valid;
      end
      for (int i = 2; i <= NSTAGE; i++) begin
        if (ld[i]) begin
          v_r[i] <= v_r[i-1];
        end
      end
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (ld[1]) begin
      ang1_r  <= in_chan.angle_value;
      unit1_r <= in_chan.unit_code;
      kind1_r <= in_chan.angle_kind;
    end
  end

  // Sign and magnitude; the most negative code maps to 2^53 unsigned
  always_comb begin
    ctl1.unit = unit1_r;
    ctl1.kind = kind1_r;
    ctl1.neg  = ang1_r[ANGLE_W-1];
    mag1      = ctl1.neg ? (~ang1_r + ANGLE_W'(1)) : ang1_r;
  end

  always_ff @(posedge clk) begin
    if (ld[2]) begin
      ctl_r[0] <= ctl1;
    end
    for (int i = 1; i < MID_STAGES; i++) begin
      if (ld[i+2]) begin
        ctl_r[i] <= ctl_r[i-1];
      end
    end
  end

  assign ctl5 = ctl_r[MID_STAGES-1];

  // Degree/minute/second conversion path
  adms_conv #(.FRAC_BITS(FRAC_BITS)) u_conv (
    .clk    (clk),
    .en     (ld[NSTAGE-1:2]),
    .mag    (mag1),
    .ctl_s1 (ctl1),
    .ctl_s2 (ctl_r[0]),
    .res    (conv_res)
  );

  // Packed DMS validation path
  adms_pchk #(.FRAC_BITS(FRAC_BITS)) u_pchk (
    .clk    (clk),
    .en     (ld[NSTAGE-1:2]),
    .mag    (mag1),
    .ctl_s1 (ctl1),
    .res    (pchk_res)
  );

  // Result stage: pack, seconds field of packed input, status priority
  always_comb begin
    conv_pk = PK_W'(conv_res.dd) * PK_W'(PK_PER_DEG) +
              PK_W'(conv_res.mm) * PK_W'(PK_PER_MIN) + PK_W'(conv_res.ss);

    wk_full = pchk_res.wm - WKF_W'(pchk_res.qk0) * WKF_W'(KILO);
    wk11    = wk_full[WK_W:0];
    wk      = (wk11 >= (WK_W+1)'(KILO)) ? WK_W'(wk11 - (WK_W+1)'(KILO)) : wk11[WK_W-1:0];

    if (ctl5.unit != UNIT_DMS) begin
      stat_nxt = conv_res.oor ? ST_RANGE : ST_OK;
      mag_out  = conv_pk;
    end else begin
      mag_out = pchk_res.val;
      if (pchk_res.bad) begin
        stat_nxt = ST_RANGE;
      end else if (ctl5.kind[1] && pchk_res.zero) begin
        stat_nxt = ST_NONPOS;
      end else if ((pchk_res.wm > WM_W'(BAD_MIN_LIM)) ||
                   ((pchk_res.wm == WM_W'(BAD_MIN_LIM)) && pchk_res.pnz)) begin
        stat_nxt = ST_BAD_MIN;
      end else if ((wk > WK_W'(BAD_SEC_LIM)) ||
                   ((wk == WK_W'(BAD_SEC_LIM)) && pchk_res.pnz)) begin
        stat_nxt = ST_BAD_SEC;
      end else begin
        stat_nxt = ST_OK;
      end
    end

    if (stat_nxt != ST_OK) begin
      dms_nxt = '0;
    end else if (ctl5.neg) begin
      dms_nxt = -DMS_W'(mag_out);
    end else begin
      dms_nxt = DMS_W'(mag_out);
    end
  end

  always_ff @(posedge clk) begin
    if (ld[NSTAGE]) begin
      dms_r  <= dms_nxt;
      stat_r <= stat_nxt;
    end
  end

  assign out_chan.valid     = v_r[NSTAGE];
  assign out_chan.dms_value = dms_r;
  assign out_chan.status    = stat_r;

  // Input stalls only when the whole pipe is full behind a waiting result
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_chan.ready |-> out_chan.valid)
    else $error("input stalled with no result waiting");

  // An accepted item occupies the input register on the next edge
  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready) |=> v_r[1])
    else $error("accepted item lost at input register");

  // In-range conversions split into sane degree and minute fields
  a_conv_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[NSTAGE-1] && (ctl5.unit != UNIT_DMS) && !conv_res.oor) |->
      ((conv_res.mm < MM_W'(MIN_PER_DEG)) && (conv_res.dd <= DD_W'(360))))
    else $error("conversion split out of range");

  // Any failure status carries a zero value
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && (out_chan.status != ST_OK)) |-> (out_chan.dms_value == '0))
    else $error("nonzero value with failure status");

  // Status codes stay within the defined set
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |-> (out_chan.status <= ST_BAD_SEC))
    else $error("undefined status code");

endmodule

### dv/angle_to_packed_dms_top_test.sv
`timescale 1ns / 1ps

// Drives angle items into angle_to_packed_dms_top and checks every result
// against a local predictor. A directed part covers the field extremes,
// inclusive range bounds, the 59.999 s carry and the packed DMS checks.
// Random angles then follow at varying pace on both channels.

module angle_to_packed_dms_top_test;
  import adms_pkg::*;

  localparam int FRAC     = FRAC_BITS_DEF;
  localparam int PIPE_LAT = MID_STAGES + 2;  // register stages, input to result
  localparam int WDOG_LIM = 1000;            // cycles with no item moving
  localparam int PACE_MAX = 8;

  // Kind code three is accepted and behaves as other
  localparam logic [KIND_W-1:0] KIND_ALT = 2'd3;

  localparam logic signed [ANGLE_W-1:0] ANGLE_MAX = {1'b0, {(ANGLE_W-1){1'b1}}};
  localparam logic signed [ANGLE_W-1:0] ANGLE_MIN = {1'b1, {(ANGLE_W-1){1'b0}}};

  typedef struct packed {
    logic signed [DMS_W-1:0] dms;
    logic [STAT_W-1:0]       st;
  } dms_result_t;

  logic clk = 1'b0;
  logic rst_n;

  adms_in_if  in_chan();
  adms_out_if out_chan();

  angle_to_packed_dms_top #(.FRAC_BITS(FRAC)) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Results expected from accepted items, oldest first
  dms_result_t pending_dms[$];
  int          mismatch_count = 0;

  // Pace of each side: per-item wait is drawn from 0 to these maxima
  int src_gap_max = 0;
  int snk_stall_max = 0;

  // Receiver bookkeeping; out_taken is shared by the checker and the ready driver
  bit out_taken = 1'b1;
  int stall_left = 0;

  // ------------------------------------------------------------------
  // Predictor
  // ------------------------------------------------------------------

  function automatic longint unsigned deg_limit(input logic [KIND_W-1:0] kind);
    if (kind == KIND_LAT) return 90;
    if (kind == KIND_LON) return 180;
    return 360;
  endfunction

  // Converts one input item to its packed DMS value and status.
  function automatic dms_result_t predict_dms(input logic signed [ANGLE_W-1:0] ang,
                                              input logic [UNIT_W-1:0] unit,
                                              input logic [KIND_W-1:0] kind);
    dms_result_t       r;
    logic [ANGLE_W-1:0] m54;
    longint unsigned   mag, whole, part, k, ms, dd, rr, mm, ss, pk, lim, t, frac_mask;
    longint            hi, lo, v;
    logic              neg, other;
    neg   = ang[ANGLE_W-1];
    m54   = neg ? (~ang + 54'd1) : ang;
    mag   = 64'(m54);
    other = (kind != KIND_LAT) && (kind != KIND_LON);
    frac_mask = (64'd1 << FRAC) - 64'd1;
    lim   = deg_limit(kind) * 64'd1000000;
    hi    = $signed(lim * 64'd1000);
    lo    = other ? 64'sd0 : -hi;
    r.st  = ST_OK;
    v     = 0;
    if (unit != UNIT_DMS) begin
      case (unit)
        UNIT_DEG: k = 3600000;
        UNIT_MIN: k = 60000;
        default:  k = 1000;
      endcase
      whole = mag >> FRAC;
      part  = mag & frac_mask;
      // whole part saturates; anything that large is out of range anyway
      if (whole > (64'd1 << 24)) whole = 64'd1 << 24;
      ms = whole * k + ((part * k) >> FRAC);
      dd = ms / 3600000;
      rr = ms % 3600000;
      mm = rr / 60000;
      ss = rr % 60000;
      // 59.999 s rounds up into the minutes, 60 min into the degrees
      if (ss >= 59999) begin
        ss = 0;
        mm++;
        if (mm >= 60) begin
          mm = 0;
          dd++;
        end
      end
      pk = dd * 64'd1000000000 + mm * 64'd1000000 + ss;
      v  = $signed(pk);
      if (neg) v = -v;
      if (v > hi || v < lo) r.st = ST_RANGE;
    end else begin
      // packed input is validated only, in priority order
      if (mag > (lim << FRAC) || (other && neg && mag != 0))
        r.st = ST_RANGE;
      else if (other && mag == 0)
        r.st = ST_NONPOS;
      else if (mag % (64'd1000000 << FRAC) > (64'd60060 << FRAC))
        r.st = ST_BAD_MIN;
      else if (mag % (64'd1000 << FRAC) > (64'd60 << FRAC))
        r.st = ST_BAD_SEC;
      else begin
        t = (mag >> FRAC) * 64'd1000 + (((mag & frac_mask) * 64'd1000) >> FRAC);
        v = $signed(t);
        if (neg) v = -v;
      end
    end
    if (r.st != ST_OK) v = 0;
    r.dms = v[DMS_W-1:0];
    return r;
  endfunction

  // ------------------------------------------------------------------
  // Stimulus helpers
  // ------------------------------------------------------------------

  // Signed fixed-point angle from sign, whole units and fraction bits
  function automatic logic signed [ANGLE_W-1:0] make_fx(input bit neg,
                                                        input longint unsigned whole,
                                                        input logic [FRAC-1:0] frac);
    logic [ANGLE_W-1:0] mag;
    mag = ANGLE_W'(whole << FRAC) | ANGLE_W'(frac);
    return neg ? -mag : mag;
  endfunction

  function automatic logic [ANGLE_W-1:0] rand_angle_bits();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[ANGLE_W-1:0];
  endfunction

  // Either side runs flat out or idles up to the maximum
  task automatic pick_pace();
    src_gap_max   = $urandom_range(0, 1) ? PACE_MAX : 0;
    snk_stall_max = $urandom_range(0, 1) ? PACE_MAX : 0;
  endtask

  // Sends one item. valid stays high on return so that back-to-back items
  // need no extra assignment; a gap in the next call or end_of_input lowers it.
  task automatic send_angle(input logic signed [ANGLE_W-1:0] ang,
                            input logic [UNIT_W-1:0] unit,
                            input logic [KIND_W-1:0] kind);
    int gap;
    gap = $urandom_range(0, src_gap_max);
    @(negedge clk);
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_chan.valid       <= 1'b1;
    in_chan.angle_value <= ang;
    in_chan.unit_code   <= unit;
    in_chan.angle_kind  <= kind;
    do @(posedge clk); while (in_chan.ready !== 1'b1);
    pending_dms.push_back(predict_dms(ang, unit, kind));
  endtask

  task automatic end_of_input();
    @(negedge clk);
    in_chan.valid <= 1'b0;
  endtask

  // Sender holds off until every result is back
  task automatic wait_all_results();
    end_of_input();
    while (pending_dms.size() != 0) @(posedge clk);
    repeat (PIPE_LAT) @(posedge clk);
  endtask

  // ------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------

  task automatic test_field_extremes();
    send_angle('0, UNIT_DEG, KIND_LAT);
    send_angle(ANGLE_MAX, UNIT_DEG, KIND_OTHER);
    send_angle(ANGLE_MIN, UNIT_MIN, KIND_LON);
    // whole part right at the saturation point, and beyond it
    send_angle(make_fx(0, 64'd1 << 24, '0), UNIT_DEG, KIND_LON);
    send_angle(make_fx(1, (64'd1 << 24) + 5, FRAC'(123)), UNIT_SEC, KIND_ALT);
  endtask

  task automatic test_range_bounds();
    send_angle(make_fx(0, 90, '0), UNIT_DEG, KIND_LAT);
    send_angle(make_fx(1, 90, '0), UNIT_DEG, KIND_LAT);
    send_angle(make_fx(0, 90, FRAC'(1 << 20)), UNIT_DEG, KIND_LAT);
    send_angle(make_fx(0, 360 * 3600, '0), UNIT_SEC, KIND_OTHER);
    send_angle(make_fx(1, 1, '0), UNIT_SEC, KIND_OTHER);
    // one lsb below zero truncates to zero, accepted for other
    send_angle(make_fx(1, 0, FRAC'(1)), UNIT_DEG, KIND_OTHER);
  endtask

  task automatic test_seconds_carry();
    send_angle(make_fx(0, 59, FRAC'(24'hFFF000)), UNIT_SEC, KIND_LAT);
    send_angle(make_fx(1, 3599, FRAC'(24'hFFF000)), UNIT_SEC, KIND_LON);
    // carries up to exactly 90 deg, still a valid latitude
    send_angle(make_fx(0, 89, FRAC'(24'hFFFFFF)), UNIT_DEG, KIND_LAT);
    send_angle(make_fx(0, 59, FRAC'(24'hFFFFF0)), UNIT_MIN, KIND_OTHER);
  endtask

  task automatic test_packed_checks();
    send_angle('0, UNIT_DMS, KIND_OTHER);
    send_angle('0, UNIT_DMS, KIND_LAT);
    send_angle(make_fx(0, 45030020, FRAC'(1 << (FRAC - 1))), UNIT_DMS, KIND_LAT);
    send_angle(make_fx(0, 61000, '0), UNIT_DMS, KIND_LON);
    send_angle(make_fx(0, 100, '0), UNIT_DMS, KIND_LON);
    send_angle(make_fx(0, 60060, '0), UNIT_DMS, KIND_LAT);
    send_angle(make_fx(0, 60060, FRAC'(1)), UNIT_DMS, KIND_LAT);
    send_angle(make_fx(1, 1, '0), UNIT_DMS, KIND_OTHER);
    send_angle(make_fx(0, 90000000, FRAC'(1)), UNIT_DMS, KIND_LAT);
    send_angle(make_fx(1, 45030020, '0), UNIT_DMS, KIND_LON);
    send_angle(make_fx(0, 360000000, '0), UNIT_DMS, KIND_ALT);
  endtask

  // Mostly in-range angles in degrees, minutes or seconds, with the
  // bounds and the seconds carry hit often
  task automatic test_random_angles(input int n, input bit vary_pace);
    logic [UNIT_W-1:0] unit;
    logic [KIND_W-1:0] kind;
    longint unsigned   lim_units, whole;
    logic [FRAC-1:0]   frac;
    bit                neg;
    for (int i = 0; i < n; i++) begin
      if (vary_pace && (i % 100 == 0)) pick_pace();
      unit = UNIT_W'($urandom_range(0, 2));
      kind = KIND_W'($urandom_range(0, 3));
      frac = FRAC'($urandom);
      case ($urandom_range(0, 9))
        0: begin
          unit = UNIT_SEC;
          whole = $urandom_range(0, deg_limit(kind) * 60 - 1) * 60 + 59;
          if ($urandom_range(0, 1)) whole = $urandom_range(0, deg_limit(kind) - 1) * 3600 + 3599;
          frac = FRAC'((1 << FRAC) - 1 - $urandom_range(0, (1 << FRAC) / 1000 - 1));
        end
        1: begin
          lim_units = deg_limit(kind) * ((unit == UNIT_DEG) ? 1 : (unit == UNIT_MIN) ? 60 : 3600);
          whole = lim_units;
          if ($urandom_range(0, 1)) frac = '0;
        end
        2: begin
          lim_units = deg_limit(kind) * ((unit == UNIT_DEG) ? 1 : (unit == UNIT_MIN) ? 60 : 3600);
          whole = lim_units + $urandom_range(1, 1000);
        end
        default: begin
          lim_units = deg_limit(kind) * ((unit == UNIT_DEG) ? 1 : (unit == UNIT_MIN) ? 60 : 3600);
          whole = $urandom_range(0, lim_units);
        end
      endcase
      if (kind == KIND_LAT || kind == KIND_LON) neg = $urandom_range(0, 1);
      else neg = ($urandom_range(0, 9) == 0);
      send_angle(make_fx(neg, whole, frac), unit, kind);
    end
  endtask

  // Packed DDDMMMSSS inputs; well formed most of the time, with bad
  // minute and second fields, zeros and out-of-range degrees mixed in
  task automatic test_random_packed(input int n);
    logic [KIND_W-1:0] kind;
    longint unsigned   dd, mm, sec;
    logic [FRAC-1:0]   frac;
    bit                neg;
    for (int i = 0; i < n; i++) begin
      if (i % 100 == 0) pick_pace();
      kind = KIND_W'($urandom_range(0, 3));
      dd   = $urandom_range(0, deg_limit(kind));
      mm   = $urandom_range(0, 59);
      sec  = $urandom_range(0, 59);
      frac = FRAC'($urandom);
      case ($urandom_range(0, 11))
        0: mm = $urandom_range(60, 999);
        1: sec = $urandom_range(60, 999);
        2: dd = deg_limit(kind) + $urandom_range(0, 3);
        3: begin
          dd = 0;
          mm = 0;
          sec = 0;
          if ($urandom_range(0, 1)) frac = '0;
        end
        4: mm = 60;
        default: ;
      endcase
      if (kind == KIND_LAT || kind == KIND_LON) neg = $urandom_range(0, 1);
      else neg = ($urandom_range(0, 9) == 0);
      send_angle(make_fx(neg, dd * 1000000 + mm * 1000 + sec, frac), UNIT_DMS, kind);
    end
  endtask

  // Unconstrained bits on every field
  task automatic test_random_noise(input int n);
    for (int i = 0; i < n; i++) begin
      if (i % 50 == 0) pick_pace();
      send_angle(rand_angle_bits(), UNIT_W'($urandom_range(0, 3)),
                 KIND_W'($urandom_range(0, 3)));
    end
  endtask

  // ------------------------------------------------------------------
  // Receiver: ready low for a random number of cycles before each result
  // ------------------------------------------------------------------
  initial begin
    out_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (out_taken) begin
        stall_left = $urandom_range(0, snk_stall_max);
        out_taken  = 1'b0;
      end
      if (stall_left > 0) begin
        out_chan.ready <= 1'b0;
        stall_left--;
      end else begin
        out_chan.ready <= 1'b1;
      end
    end
  end

  // ------------------------------------------------------------------
  // Result checker
  // ------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    dms_result_t want;
    if (rst_n === 1'b1 && out_chan.valid === 1'b1 && out_chan.ready === 1'b1) begin
      out_taken = 1'b1;
      if (pending_dms.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result, expected none, got dms %0d status %0d",
                 $time, out_chan.dms_value, out_chan.status);
      end else begin
        want = pending_dms.pop_front();
        if (out_chan.dms_value !== want.dms) begin
          mismatch_count++;
          $display("%0t: dms_value mismatch, expected %0d, got %0d",
                   $time, want.dms, out_chan.dms_value);
        end
        if (out_chan.status !== want.st) begin
          mismatch_count++;
          $display("%0t: status mismatch, expected %0d, got %0d",
                   $time, want.st, out_chan.status);
        end
      end
    end
  end

  // ------------------------------------------------------------------
  // Watchdog: no item moving on either channel for too long
  // ------------------------------------------------------------------
  int idle_cycles = 0;

  always @(posedge clk) begin
    if ((in_chan.valid === 1'b1 && in_chan.ready === 1'b1) ||
        (out_chan.valid === 1'b1 && out_chan.ready === 1'b1))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WDOG_LIM) begin
      $display("simulation failed");
      $finish;
    end
  end

  // ------------------------------------------------------------------
  // Main sequence
  // ------------------------------------------------------------------
  initial begin
    rst_n               = 1'b0;
    in_chan.valid       = 1'b0;
    in_chan.angle_value = '0;
    in_chan.unit_code   = UNIT_DEG;
    in_chan.angle_kind  = KIND_LAT;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed part with both sides idling at random
    src_gap_max   = PACE_MAX;
    snk_stall_max = PACE_MAX;
    test_field_extremes();
    test_range_bounds();
    test_seconds_carry();
    test_packed_checks();
    wait_all_results();

    src_gap_max   = 0;
    snk_stall_max = 0;
    test_random_angles(60, 1'b0);  // flat out on both sides
    test_random_angles(540, 1'b1);
    wait_all_results();
    test_random_packed(350);
    test_random_noise(200);

    wait_all_results();
    if (mismatch_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
